[hdl/utcde_pkg.sv]
// -----------------------------------------------------------------------------
// utcde_pkg
// shared types, constants and the month table for the utc date to epoch
// seconds converter
// -----------------------------------------------------------------------------
package utcde_pkg;

   // field widths
   localparam int unsigned YearWidth    = 14;
   localparam int unsigned MonthWidth   = 4;
   localparam int unsigned DayWidth     = 6;
   localparam int unsigned HourWidth    = 5;
   localparam int unsigned MinuteWidth  = 6;
   localparam int unsigned SecondWidth  = 6;
   localparam int unsigned SecondsWidth = 38;

   // internal widths
   localparam int unsigned QuotWidth    = 8;   // year / 100 for a 14-bit year
   localparam int unsigned ProdWidth    = 27;  // year * reciprocal of 100
   localparam int unsigned LeapWidth    = 12;  // leap years in 1..year-1
   localparam int unsigned DaysWidth    = 23;  // whole days since the epoch
   localparam int unsigned MonthDayWidth = 9; // day of year, 0 based
   localparam int unsigned TodWidth     = 17;  // seconds of the day
   localparam int unsigned DaySecWidth  = 40;  // days * seconds per day

   // calendar constants
   localparam logic [YearWidth-1:0]  EpochYear     = 14'd1970;
   localparam logic [LeapWidth-1:0]  EpochLeaps    = 12'd477; // leaps in 1..1969
   localparam logic [12:0]           Recip100      = 13'd5243; // 2^19 / 100, rounded up
   localparam int unsigned           Recip100Shift = 19;
   localparam logic [16:0]           SecsPerDay    = 17'd86400;

   // status codes
   localparam logic StatusOk    = 1'b0;
   localparam logic StatusRange = 1'b1;

   typedef struct packed {
      logic [YearWidth-1:0]   year;
      logic [MonthWidth-1:0]  month;
      logic [DayWidth-1:0]    day;
      logic [HourWidth-1:0]   hour;
      logic [MinuteWidth-1:0] minute;
      logic [SecondWidth-1:0] second;
   } req_type;

   typedef struct packed {
      logic [SecondsWidth-1:0] epoch_seconds;
      logic                    status;
   } rsp_type;

   // days before the first of the month, zero for codes that mean nothing
   function automatic logic [MonthDayWidth-1:0] month_start_day(
      input logic [MonthWidth-1:0] month
   );
      logic [MonthDayWidth-1:0] d;
      case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

[hdl/utc_date_to_epoch_seconds.sv]
// -----------------------------------------------------------------------------
// utc_date_to_epoch_seconds
// five stage pipeline turning split utc date and time fields into seconds
// since 1970-01-01, with a range status for bad fields
// -----------------------------------------------------------------------------
// throughput: one item every cycle; busy is always low, as every stage
//   moves on each clock and the receiver cannot stall
// the stages are the year reciprocal multiply, leap counting, day sum,
//   the days by 86400 multiply and the final add
// reset clears the stage valid bits only; no item is in flight afterwards
// -----------------------------------------------------------------------------
module utc_date_to_epoch_seconds (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  utcde_pkg::req_type  req_data,
   output logic                rsp_valid,
   output utcde_pkg::rsp_type  rsp_data
);

   // ---------------------------------------------------------------- stage 1
   logic                                  s1_valid_ff;
   logic                                  s1_err_ff,    s1_err_in;
   logic [utcde_pkg::YearWidth-1:0]       s1_year_ff;
   logic [utcde_pkg::YearWidth-1:0]       s1_year_m1_ff, s1_year_m1_in;
   logic                                  s1_after_ff,  s1_after_in;
   logic [utcde_pkg::MonthWidth-1:0]      s1_month_ff;
   logic [utcde_pkg::DayWidth-1:0]        s1_day_ff;
   logic [utcde_pkg::HourWidth-1:0]       s1_hour_ff;
   logic [utcde_pkg::MinuteWidth-1:0]     s1_minute_ff;
   logic [utcde_pkg::SecondWidth-1:0]     s1_second_ff;
   logic [utcde_pkg::ProdWidth-1:0]       s1_prod_m1_ff, s1_prod_m1_in;
   logic [utcde_pkg::ProdWidth-1:0]       s1_prod_ff,   s1_prod_in;

   // range checks, year - 1 and both reciprocal products
   always_comb begin
      s1_err_in = (req_data.month < 4'd1) || (req_data.month > 4'd12) ||
                  (req_data.day < 6'd1) || (req_data.day > 6'd31) ||
                  (req_data.hour > 5'd23) || (req_data.minute > 6'd59) ||
                  (req_data.second > 6'd60);
      s1_after_in   = req_data.year > utcde_pkg::EpochYear;
      s1_year_m1_in = req_data.year - 14'd1;
      s1_prod_m1_in = utcde_pkg::ProdWidth'(s1_year_m1_in) *
                      utcde_pkg::ProdWidth'(utcde_pkg::Recip100);
      s1_prod_in    = utcde_pkg::ProdWidth'(req_data.year) *
                      utcde_pkg::ProdWidth'(utcde_pkg::Recip100);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_err_ff     <= s1_err_in;
      s1_after_ff   <= s1_after_in;
      s1_year_ff    <= req_data.year;
      s1_year_m1_ff <= s1_year_m1_in;
      s1_month_ff   <= req_data.month;
      s1_day_ff     <= req_data.day;
      s1_hour_ff    <= req_data.hour;
      s1_minute_ff  <= req_data.minute;
      s1_second_ff  <= req_data.second;
      s1_prod_m1_ff <= s1_prod_m1_in;
      s1_prod_ff    <= s1_prod_in;
   end

   // ---------------------------------------------------------------- stage 2
   logic                                  s2_valid_ff;
   logic                                  s2_err_ff;
   logic                                  s2_after_ff;
   logic [utcde_pkg::DaysWidth-1:0]       s2_span365_ff, s2_span365_in;
   logic [utcde_pkg::LeapWidth-1:0]       s2_extra_ff,  s2_extra_in;
   logic [utcde_pkg::MonthDayWidth-1:0]   s2_yday_ff,   s2_yday_in;
   logic                                  s2_leap_add_ff, s2_leap_add_in;
   logic [utcde_pkg::HourWidth-1:0]       s2_hour_ff;
   logic [utcde_pkg::MinuteWidth-1:0]     s2_minute_ff;
   logic [utcde_pkg::SecondWidth-1:0]     s2_second_ff;

   logic [utcde_pkg::QuotWidth-1:0]       s2_q_m1;
   logic [utcde_pkg::QuotWidth-1:0]       s2_q;
   logic [utcde_pkg::LeapWidth-1:0]       s2_leaps;
   logic [utcde_pkg::YearWidth-1:0]       s2_rem100;
   logic [utcde_pkg::YearWidth-1:0]       s2_span;
   logic                                  s2_is_leap;

   // leap count, leap year test, whole year days and day of year
   always_comb begin
      s2_q_m1   = s1_prod_m1_ff[utcde_pkg::Recip100Shift +: utcde_pkg::QuotWidth];
      s2_q      = s1_prod_ff[utcde_pkg::Recip100Shift +: utcde_pkg::QuotWidth];
      s2_leaps  = utcde_pkg::LeapWidth'(s1_year_m1_ff >> 2) -
                  utcde_pkg::LeapWidth'(s2_q_m1) +
                  utcde_pkg::LeapWidth'(s2_q_m1 >> 2);
      s2_extra_in = s2_leaps - utcde_pkg::EpochLeaps;
      s2_rem100 = s1_year_ff - utcde_pkg::YearWidth'(s2_q) * 14'd100;
      s2_is_leap = ((s1_year_ff[1:0] == 2'd0) && (s2_rem100 != '0)) ||
                   ((s2_rem100 == '0) && (s2_q[1:0] == 2'd0));
      s2_leap_add_in = (s1_month_ff > 4'd2) && s2_is_leap;
      s2_span       = s1_year_ff - utcde_pkg::EpochYear;
      s2_span365_in = utcde_pkg::DaysWidth'(s2_span) * 23'd365;
      s2_yday_in    = utcde_pkg::month_start_day(s1_month_ff) +
                      utcde_pkg::MonthDayWidth'(s1_day_ff) - 9'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_err_ff      <= s1_err_ff;
      s2_after_ff    <= s1_after_ff;
      s2_span365_ff  <= s2_span365_in;
      s2_extra_ff    <= s2_extra_in;
      s2_yday_ff     <= s2_yday_in;
      s2_leap_add_ff <= s2_leap_add_in;
      s2_hour_ff     <= s1_hour_ff;
      s2_minute_ff   <= s1_minute_ff;
      s2_second_ff   <= s1_second_ff;
   end

   // ---------------------------------------------------------------- stage 3
   logic                                  s3_valid_ff;
   logic                                  s3_err_ff;
   logic [utcde_pkg::DaysWidth-1:0]       s3_days_ff, s3_days_in;
   logic [utcde_pkg::TodWidth-1:0]        s3_tod_ff,  s3_tod_in;
   logic [utcde_pkg::DaysWidth-1:0]       s3_whole;

   // total days and seconds of the day
   always_comb begin
      s3_whole   = s2_after_ff ?
                   s2_span365_ff + utcde_pkg::DaysWidth'(s2_extra_ff) : '0;
      s3_days_in = s3_whole + utcde_pkg::DaysWidth'(s2_yday_ff) +
                   utcde_pkg::DaysWidth'(s2_leap_add_ff);
      s3_tod_in  = utcde_pkg::TodWidth'(s2_hour_ff) * 17'd3600 +
                   utcde_pkg::TodWidth'(s2_minute_ff) * 17'd60 +
                   utcde_pkg::TodWidth'(s2_second_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_err_ff  <= s2_err_ff;
      s3_days_ff <= s3_days_in;
      s3_tod_ff  <= s3_tod_in;
   end

   // ---------------------------------------------------------------- stage 4
   logic                                  s4_valid_ff;
   logic                                  s4_err_ff;
   logic [utcde_pkg::SecondsWidth-1:0]    s4_day_secs_ff, s4_day_secs_in;
   logic [utcde_pkg::TodWidth-1:0]        s4_tod_ff;
   logic [utcde_pkg::DaySecWidth-1:0]     s4_prod;

   // days to seconds, wrapped to the output width
   always_comb begin
      s4_prod        = utcde_pkg::DaySecWidth'(s3_days_ff) *
                       utcde_pkg::DaySecWidth'(utcde_pkg::SecsPerDay);
      s4_day_secs_in = s4_prod[utcde_pkg::SecondsWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_err_ff      <= s3_err_ff;
      s4_day_secs_ff <= s4_day_secs_in;
      s4_tod_ff      <= s3_tod_ff;
   end

   // ---------------------------------------------------------------- stage 5
   logic                                  rsp_valid_ff;
   utcde_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   // final add, zero seconds and range status on a bad field
   always_comb begin
      if (s4_err_ff) begin
         rsp_data_in.epoch_seconds = '0;
         rsp_data_in.status        = utcde_pkg::StatusRange;
      end else begin
         rsp_data_in.epoch_seconds = s4_day_secs_ff +
                                     utcde_pkg::SecondsWidth'(s4_tod_ff);
         rsp_data_in.status        = utcde_pkg::StatusOk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s4_valid_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // outputs
   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
